>>> sv/tasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tasp_pkg;

    localparam int DIST_WIDTH = 16;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 2;

    // width of the packed input payload, rounded up to whole bytes
    localparam int IN_FIELDS_W = 3 * DIST_WIDTH + 6;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    typedef logic [DIST_WIDTH-1:0] dist_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t CFG_HOME_DIST_A = 2'd0;
    localparam cfg_idx_t CFG_HOME_DIST_B = 2'd1;
    localparam cfg_idx_t CFG_HOME_DIST_C = 2'd2;

    // item kinds carried in tuser
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam dist_t HOME_DIST_A_RST = dist_t'(6800);
    localparam dist_t HOME_DIST_B_RST = dist_t'(6554);
    localparam dist_t HOME_DIST_C_RST = dist_t'(6520);

    typedef struct packed {
        dist_t [NUM_AXES-1:0]  target;
        dist_t                 step_index;
        logic  [NUM_AXES-1:0]  limit_latched;
        logic  [NUM_AXES-1:0]  reversed_once;
        logic  [NUM_AXES-1:0]  dir_levels;
        logic                  moving;
    } state_t;

    typedef struct packed {
        logic                  func;
        dist_t [NUM_AXES-1:0]  counts;
        logic  [NUM_AXES-1:0]  reverse;
        logic  [NUM_AXES-1:0]  limit;
    } item_t;

    typedef struct packed {
        logic [NUM_AXES-1:0] step;
        logic [NUM_AXES-1:0] dir_level;
        logic                busy;
        logic                done;
    } result_t;

endpackage

`default_nettype wire

>>> sv/tasp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tasp_cfg_regs
    import tasp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire cfg_idx_t              wr_index,
    input  wire dist_t                 wr_data,
    output dist_t [NUM_AXES-1:0]       home_dist
);

    dist_t [NUM_AXES-1:0] home_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_dist_reg[0] <= HOME_DIST_A_RST;
            home_dist_reg[1] <= HOME_DIST_B_RST;
            home_dist_reg[2] <= HOME_DIST_C_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_HOME_DIST_A: home_dist_reg[0] <= wr_data;
                CFG_HOME_DIST_B: home_dist_reg[1] <= wr_data;
                CFG_HOME_DIST_C: home_dist_reg[2] <= wr_data;
                default:         ; // unused index, write dropped
            endcase
        end
    end

    assign home_dist = home_dist_reg;

endmodule

`default_nettype wire

>>> sv/tasp_step_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tasp_step_core
    import tasp_pkg::*;
(
    input  wire state_t                state_cur,
    input  wire item_t                 item,
    input  wire dist_t [NUM_AXES-1:0]  home_dist,
    output state_t                     state_next,
    output result_t                    result
);

    always_comb
    begin
        state_t                st;
        logic [NUM_AXES-1:0]   steps;
        logic [NUM_AXES-1:0]   lim;
        logic                  any_left;

        st       = state_cur;
        steps    = '0;
        lim      = '0;
        any_left = 1'b0;
        result   = '0;

        if (item.func == FUNC_START)
        begin
            // start: load counts, set pins, clear the move's marks
            st.target        = item.counts;
            st.dir_levels    = ~item.reverse;
            st.step_index    = '0;
            st.limit_latched = '0;
            st.reversed_once = '0;
            for (int k = 0; k < NUM_AXES; k++)
                if (item.counts[k] != '0)
                    any_left = 1'b1;
            st.moving   = any_left;
            result.busy = any_left;
            result.done = !any_left;
        end
        else if (state_cur.moving)
        begin
            lim = state_cur.limit_latched | item.limit;
            st.limit_latched = lim;
            // axes in order a, b, c; a reversal clears the index for later axes
            for (int k = 0; k < NUM_AXES; k++)
            begin
                if (st.step_index < st.target[k])
                begin
                    if (lim[k] && !st.reversed_once[k])
                    begin
                        st.reversed_once[k] = 1'b1;
                        st.step_index       = '0;
                        st.dir_levels[k]    = 1'b0;
                        st.target[k]        = home_dist[k];
                    end
                    steps[k] = 1'b1;
                end
            end
            st.step_index = st.step_index + dist_t'(1);
            for (int k = 0; k < NUM_AXES; k++)
                if (st.target[k] > st.step_index)
                    any_left = 1'b1;
            if (!any_left)
            begin
                st.moving        = 1'b0;
                st.limit_latched = '0;
                st.reversed_once = '0;
            end
            result.step = steps;
            result.busy = any_left;
            result.done = !any_left;
        end

        result.dir_level = st.dir_levels;
        state_next       = st;
    end

endmodule

`default_nettype wire

>>> sv/three_axis_step_pulser_homing.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-axis step pulse sequencer with limit-switch homing. A start item
// (tuser 0) loads the three step counts and sets the direction pins, low for
// a set reverse bit; a tick item (tuser 1) is one step period: it latches the
// limit events, pulses each axis whose count is above the shared step index
// and, on the first limit hit of an axis, reverses that axis onto its homing
// distance and restarts the index. Every item gives exactly one result item
// with the step pulses, the pin levels and busy/done flags. An item is taken
// every clock unless both registers are full and the sink stalls, when the
// input is held off. The item is held in the input register, then passes
// through the step logic into the result register, which holds it while the
// sink stalls. The user must write the homing distances over the cfg port
// only while no item is in flight; the block itself does not enforce it.

module three_axis_step_pulser_homing
    import tasp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // input items
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // dist_a[15:0], dist_b[31:16], dist_c[47:32], reverse_a, reverse_b,
    // reverse_c, limit_a, limit_b, limit_c, zero padding to 56 bits
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // func: 0 start, 1 tick
    input  wire logic                    s_axis_tuser,

    // result items
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // step_a, step_b, step_c, dir_level_a, dir_level_b, dir_level_c,
    // busy_res, done_res
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,

    // configuration writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire cfg_idx_t                cfg_index,
    input  wire dist_t                   cfg_data
);

    localparam int REV_LSB = 3 * DIST_WIDTH;
    localparam int LIM_LSB = REV_LSB + NUM_AXES;

    logic     in_vld_reg;
    item_t    in_item_reg;
    logic     out_vld_reg;
    result_t  out_res_reg;
    state_t   state_reg;

    state_t               state_next;
    result_t              res_next;
    item_t                item_unpacked;
    dist_t [NUM_AXES-1:0] home_dist;
    logic                 out_free;
    logic                 in_accept;
    logic                 advance;

    // unpack the stream payload into item fields
    always_comb
    begin
        item_unpacked.func      = s_axis_tuser;
        item_unpacked.counts[0] = s_axis_tdata[DIST_WIDTH-1:0];
        item_unpacked.counts[1] = s_axis_tdata[2*DIST_WIDTH-1:DIST_WIDTH];
        item_unpacked.counts[2] = s_axis_tdata[3*DIST_WIDTH-1:2*DIST_WIDTH];
        item_unpacked.reverse   = s_axis_tdata[REV_LSB+NUM_AXES-1:REV_LSB];
        item_unpacked.limit     = s_axis_tdata[LIM_LSB+NUM_AXES-1:LIM_LSB];
    end

    // result slot is free when empty or being drained this cycle
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign advance       = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    tasp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .home_dist (home_dist)
    );

    tasp_step_core u_core
    (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .home_dist  (home_dist),
        .state_next (state_next),
        .result     (res_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (out_free)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_item_reg <= item_unpacked;
    end

    // move state and result register, updated as each item passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_res_reg.done, out_res_reg.busy,
                            out_res_reg.dir_level, out_res_reg.step};

endmodule

`default_nettype wire
